// ----- rtl/sem_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; used by sem_lane, the top level and the testbench.
package sem_pkg;

  localparam int MaxWidth = 1024;
  localparam int AddrW    = $clog2(MaxWidth);
  localparam int ColW     = AddrW;
  localparam int CfgWW    = 11;
  localparam int CfgHW    = 16;
  localparam int RowW     = CfgHW + 1;
  localparam int ChanW    = 8;
  localparam int PixW     = 3 * ChanW;
  localparam int GradW    = 11;
  localparam int AbsW     = 10;
  localparam int SqW      = 2 * AbsW + 1;
  localparam int RootW    = 8;
  localparam int RemW     = 11;
  localparam int NumW     = 2 * RootW;
  localparam int IterW    = 3;

  localparam logic [SqW-1:0]   SatLimit = SqW'(65280);
  localparam logic [CfgWW-1:0] WidthMax = CfgWW'(MaxWidth);

  localparam logic OP_PIXEL   = 1'b0;
  localparam logic OP_DRAIN   = 1'b1;
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef logic [PixW-1:0] pixel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_OUT
  } sem_state_t;

endpackage

// ----- rtl/sem_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sem_lane.sv -----
`timescale 1ns / 1ps
// One color channel: squares the gradient parts, then takes a rounded
// square root one bit per cycle with saturation at 255. Depends on sem_pkg.
module sem_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sem_pkg::AbsW-1:0]  ax,
  input  logic [sem_pkg::AbsW-1:0]  ay,
  output logic                      done,
  output logic [sem_pkg::ChanW-1:0] mag
);
  import sem_pkg::*;

  logic [AbsW-1:0]  axr, ayr;
  logic             mul_pend, busy, sat;
  logic [IterW-1:0] cnt;
  logic [NumW-1:0]  nsh;
  logic [RootW-1:0] root;
  logic [RemW-1:0]  rem;
  logic [SqW-1:0]   sq;
  logic [RemW-1:0]  rem_sh, trial;
  logic             ge, rnd;

  assign sq     = SqW'(axr) * SqW'(axr) + SqW'(ayr) * SqW'(ayr);
  assign rem_sh = {rem[RemW-3:0], nsh[NumW-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = rem_sh >= trial;
  assign rnd    = rem > RemW'(root);
  assign mag    = sat ? {ChanW{1'b1}} : root + RootW'(rnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_pend <= 1'b0;
      busy     <= 1'b0;
      done     <= 1'b0;
      cnt      <= '0;
    end else if (start) begin
      mul_pend <= 1'b1;
      busy     <= 1'b0;
      done     <= 1'b0;
    end else if (mul_pend) begin
      mul_pend <= 1'b0;
      busy     <= 1'b1;
      cnt      <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == {IterW{1'b1}}) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      axr <= ax;
      ayr <= ay;
    end else if (mul_pend) begin
      sat  <= sq > SatLimit;
      nsh  <= sq[NumW-1:0];
      root <= '0;
      rem  <= '0;
    end else if (busy) begin
      nsh  <= {nsh[NumW-3:0], 2'b00};
      root <= {root[RootW-2:0], ge};
      rem  <= ge ? rem_sh - trial : rem_sh;
    end
  end

endmodule

// ----- rtl/sobel_edge_magnitude_rgb.sv -----
`timescale 1ns / 1ps
// Streaming 3x3 Sobel edge magnitude for RGB frames, top level.
// Each accepted pixel or drain transaction is read from the line store and updates the window;
// one that yields a result is then squared and taken through 8 root steps before output.
// A result waits in the output register while the next transaction is taken.
// Synchronous reset clears position, window and handshakes; line stores hold
// undefined data until written. Depends on sem_pkg, sem_ram and sem_lane.
module sobel_edge_magnitude_rgb (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,  // in_blue, in_green, in_red
  input  logic                       s_axis_tuser,  // op
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata,  // edge_blue, edge_green, edge_red
  output logic                       m_axis_tlast,
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [sem_pkg::CfgHW-1:0]  cfg_data
);
  import sem_pkg::*;

  sem_state_t state, state_next;

  logic [CfgWW-1:0] width_cfg, w_eff;
  logic [CfgHW-1:0] height_cfg, h_eff;
  logic [ColW-1:0]  col;
  logic [RowW-1:0]  row;
  pixel_t           bot;
  logic             last_flag;
  pixel_t           win_c1 [3];
  pixel_t           win_c2 [3];

  logic             accept, drain_now, item_ok;
  logic [2*PixW-1:0] rd_data;
  logic              ram_we;
  pixel_t            top, mid;
  pixel_t            newcol [3];
  pixel_t            ow [9];
  logic              emit, is_last;
  logic [AbsW-1:0]   ax [3];
  logic [AbsW-1:0]   ay [3];
  logic [2:0]        lane_done;
  logic [ChanW-1:0]  lane_mag [3];
  logic              out_load;

  assign w_eff = (width_cfg == '0) ? CfgWW'(1) :
                 (width_cfg > WidthMax) ? WidthMax : width_cfg;
  assign h_eff = (height_cfg == '0) ? CfgHW'(1) : height_cfg;

  assign drain_now     = row >= RowW'(h_eff);
  assign s_axis_tready = state == ST_IDLE;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign item_ok       = (s_axis_tuser == OP_DRAIN) == drain_now;
  assign out_load      = state == ST_OUT && (!m_axis_tvalid || m_axis_tready);
  assign ram_we        = state == ST_READ;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= CfgWW'(1024);
      height_cfg <= CfgHW'(768);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_WIDTH:  width_cfg <= cfg_data[CfgWW-1:0];
        CFG_HEIGHT: height_cfg <= cfg_data;
        default:    width_cfg <= width_cfg;
      endcase
    end
  end

  sem_ram #(.WIDTH(2 * PixW), .DEPTH(MaxWidth)) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col),
    .wdata ({rd_data[PixW-1:0], bot}),
    .raddr (col),
    .rdata (rd_data)
  );

  always_comb begin
    top = (row >= RowW'(2)) ? rd_data[2*PixW-1:PixW] : '0;
    mid = (row >= RowW'(1)) ? rd_data[PixW-1:0] : '0;
    newcol[0] = top;
    newcol[1] = mid;
    newcol[2] = bot;
    for (int k = 0; k < 3; k++) begin
      ow[k*3+0] = win_c1[k];
      ow[k*3+1] = win_c2[k];
      ow[k*3+2] = (col == '0) ? '0 : newcol[k];
    end
    emit    = row >= RowW'(2) || (row == RowW'(1) && col != '0);
    is_last = last_flag && row >= RowW'(h_eff) + RowW'(1);
  end

  always_comb begin
    logic signed [GradW-1:0] v [9];
    logic signed [GradW-1:0] gx, gy;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 9; i++) begin
        v[i] = $signed({3'b000, ow[i][ch*ChanW +: ChanW]});
      end
      gx = v[2] - v[0] + ((v[5] - v[3]) <<< 1) + v[8] - v[6];
      gy = v[6] - v[0] + ((v[7] - v[1]) <<< 1) + v[8] - v[2];
      ax[ch] = gx[GradW-1] ? AbsW'(-gx) : AbsW'(gx);
      ay[ch] = gy[GradW-1] ? AbsW'(-gy) : AbsW'(gy);
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    sem_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (state == ST_READ && emit),
      .ax    (ax[ch]),
      .ay    (ay[ch]),
      .done  (lane_done[ch]),
      .mag   (lane_mag[ch])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && item_ok) state_next = ST_READ;
      ST_READ: state_next = emit ? ST_CALC : ST_IDLE;
      ST_CALC: if (&lane_done) state_next = ST_OUT;
      ST_OUT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item_ok) begin
      bot       <= (s_axis_tuser == OP_DRAIN) ? '0 : s_axis_tdata;
      last_flag <= s_axis_tuser == OP_DRAIN;
    end else if (state == ST_READ) begin
      last_flag <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      for (int k = 0; k < 3; k++) begin
        win_c1[k] <= '0;
        win_c2[k] <= '0;
      end
    end else if (state == ST_READ) begin
      if (is_last) begin
        row <= '0;
        col <= '0;
        for (int k = 0; k < 3; k++) begin
          win_c1[k] <= '0;
          win_c2[k] <= '0;
        end
      end else begin
        if (CfgWW'(col) + CfgWW'(1) >= w_eff) begin
          col <= '0;
          row <= row + RowW'(1);
        end else begin
          col <= col + ColW'(1);
        end
        for (int k = 0; k < 3; k++) begin
          win_c1[k] <= (col == '0) ? '0 : win_c2[k];
          win_c2[k] <= newcol[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {lane_mag[2], lane_mag[1], lane_mag[0]};
      m_axis_tlast <= last_flag;
    end
  end

  a_done_agree: assert property (@(posedge clk) disable iff (rst)
    lane_done == 3'b000 || lane_done == 3'b111)
    else $error("channel lanes out of step");

  a_out_ready: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |-> lane_done == 3'b111)
    else $error("result stage entered before the root finished");

  a_last_wrap: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ && is_last |=> row == '0 && col == '0)
    else $error("frame end did not return to the frame start");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_OUT)
    else $error("result presented without a finished computation");

endmodule

// ----- bench/sobel_edge_magnitude_rgb_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sobel_edge_magnitude_rgb: whole frames with drain tails,
// checked against a behavioral Sobel predictor. Depends on sem_pkg and the block's RTL.
module sobel_edge_magnitude_rgb_tb;
  import sem_pkg::*;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } edge_result_t;

  localparam int StallLimit = 20000;
  localparam int HoldCycles = 2000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata = '0;
  logic              s_axis_tuser = OP_PIXEL;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;
  logic              m_axis_tlast;
  logic              cfg_we = 1'b0;
  logic              cfg_addr = CFG_WIDTH;
  logic [CfgHW-1:0]  cfg_data = '0;

  sobel_edge_magnitude_rgb dut (.*);

  // Predictor state.
  logic [CfgWW-1:0] width_reg = CfgWW'(1024);
  logic [CfgHW-1:0] height_reg = CfgHW'(768);
  pixel_t upper_line[MaxWidth];
  pixel_t middle_line[MaxWidth];
  pixel_t window[9];
  int col_pos = 0;
  int row_pos = 0;
  bit frame_done;

  edge_result_t expected_edges[$];
  int errors = 0;
  int items_taken = 0;
  int results_seen = 0;
  int frames_run = 0;
  int idle_in_pct = 0;
  int stall_pct = 0;
  int holdoff = 0;
  int quiet_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] channel_magnitude(pixel_t win[9], int ch);
    int kx[9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    int ky[9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
    int gx = 0;
    int gy = 0;
    int n;
    int s = 0;
    for (int i = 0; i < 9; i++) begin
      gx += kx[i] * int'(win[i][8*ch +: 8]);
      gy += ky[i] * int'(win[i][8*ch +: 8]);
    end
    n = gx * gx + gy * gy;
    while ((s + 1) * (s + 1) <= n) s++;
    if (n - s * s > s) s++;
    return (s > 255) ? 8'd255 : 8'(s);
  endfunction

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidth) return MaxWidth;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  function automatic logic expected_op();
    return (row_pos >= eff_height()) ? OP_DRAIN : OP_PIXEL;
  endfunction

  // Advances the predictor by one accepted transaction; items of the wrong kind leave it unchanged.
  function automatic void predict_edges(logic op, pixel_t pix);
    int w = eff_width();
    int h = eff_height();
    bit drain = row_pos >= h;
    bit emit;
    bit last;
    pixel_t top = '0;
    pixel_t mid = '0;
    pixel_t bot;
    pixel_t shifted[9];
    edge_result_t res;
    if (op != (drain ? OP_DRAIN : OP_PIXEL)) return;
    items_taken++;
    bot = drain ? '0 : pix;
    if (row_pos >= 2) top = upper_line[col_pos];
    if (row_pos >= 1) mid = middle_line[col_pos];
    upper_line[col_pos] = middle_line[col_pos];
    middle_line[col_pos] = bot;
    for (int k = 0; k < 3; k++) begin
      shifted[3*k] = window[3*k+1];
      shifted[3*k+1] = window[3*k+2];
      shifted[3*k+2] = '0;
    end
    if (col_pos != 0) begin
      shifted[2] = top;
      shifted[5] = mid;
      shifted[8] = bot;
      window = shifted;
    end else begin
      foreach (window[i]) window[i] = '0;
    end
    window[2] = top;
    window[5] = mid;
    window[8] = bot;
    emit = row_pos >= 2 || (row_pos == 1 && col_pos >= 1);
    last = drain && row_pos >= h + 1;
    if (last) begin
      row_pos = 0;
      col_pos = 0;
      foreach (window[i]) window[i] = '0;
      frame_done = 1'b1;
    end else if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
    if (emit) begin
      res.blue = channel_magnitude(shifted, 0);
      res.green = channel_magnitude(shifted, 1);
      res.red = channel_magnitude(shifted, 2);
      res.last = last;
      expected_edges.push_back(res);
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic send_item(logic op, pixel_t pix);
    if ($urandom_range(99) < idle_in_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_in_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= pix;
    do @(posedge clk); while (!s_axis_tready);
    predict_edges(op, pix);
  endtask

  task automatic wait_results_done();
    while (expected_edges.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic addr, int value);
    s_axis_tvalid <= 1'b0;
    wait_results_done();
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= CfgHW'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_WIDTH) width_reg = CfgWW'(value);
    else height_reg = CfgHW'(value);
  endtask

  function automatic pixel_t pattern_pixel(int pat, int n);
    case (pat)
      1: return '1;
      2: return (n % 2) ? '1 : '0;
      3: return '0;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  // One full frame plus its drain tail; noise_pct injects items of the wrong kind.
  task automatic run_frame(int w, int h, int pat, int noise_pct, bit hold_mid = 0,
                           bit pause_mid = 0);
    int n = 0;
    write_register(CFG_WIDTH, w);
    write_register(CFG_HEIGHT, h);
    frame_done = 1'b0;
    while (!frame_done) begin
      if ($urandom_range(99) < noise_pct)
        send_item(~expected_op(), pattern_pixel(0, n));
      if (hold_mid && n == 3) holdoff = HoldCycles;
      if (pause_mid && n == 12) begin
        s_axis_tvalid <= 1'b0;
        wait_results_done();
        @(posedge clk);
      end
      send_item(expected_op(), pattern_pixel(pat, n));
      n++;
    end
    frames_run++;
  endtask

  task automatic test_directed();
    run_frame(3, 2, 2, 20);
    run_frame(2, 3, 1, 20);
    run_frame(1, 2, 3, 0);
    run_frame(0, 0, 0, 100);
    run_frame(4, 1, 0, 10);
  endtask

  task automatic test_extremes();
    write_register(CFG_HEIGHT, 65535);
    run_frame(40, 1, 0, 0);
    run_frame(1, 100, 0, 2);
  endtask

  task automatic test_pressure();
    idle_in_pct = 0;
    stall_pct = 0;
    run_frame(5, 4, 0, 0, 1, 1);
  endtask

  task automatic test_random();
    int pct_in[4] = '{0, 86, 0, 28};
    int pct_out[4] = '{0, 0, 86, 28};
    int phase = 0;
    while (items_taken < 1350) begin
      idle_in_pct = pct_in[phase % 4];
      stall_pct = pct_out[phase % 4];
      run_frame($urandom_range(12, 1), $urandom_range(8, 1), 0, 3);
      if ((frames_run % 5) == 0) phase++;
    end
  endtask

  always @(posedge clk) begin
    if (holdoff > 0) begin
      m_axis_tready <= 1'b0;
      holdoff <= holdoff - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    edge_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_edges.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h last=%b", m_axis_tdata, m_axis_tlast));
      end else begin
        want = expected_edges.pop_front();
        if (m_axis_tdata[7:0] != want.blue)
          report_mismatch($sformatf("edge_blue %0d, want %0d", m_axis_tdata[7:0], want.blue));
        if (m_axis_tdata[15:8] != want.green)
          report_mismatch($sformatf("edge_green %0d, want %0d", m_axis_tdata[15:8],
                                    want.green));
        if (m_axis_tdata[23:16] != want.red)
          report_mismatch($sformatf("edge_red %0d, want %0d", m_axis_tdata[23:16], want.red));
        if (m_axis_tlast != want.last)
          report_mismatch($sformatf("frame_last %b, want %b", m_axis_tlast, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Timeout: no transaction for %0d cycles", StallLimit);
        $display("** sobel_edge_magnitude_rgb: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extremes();
    test_pressure();
    test_random();
    s_axis_tvalid <= 1'b0;
    wait_results_done();
    repeat (30) @(posedge clk);
    $display("Ran %0d frames up to 40 pixels wide and 100 rows high, with %0d items and %0d results,",
             frames_run, items_taken, results_seen);
    $display("including ignored items, a long output hold-off and several idle mixes.");
    if (errors == 0) begin
      $display("** sobel_edge_magnitude_rgb: PASSED **");
    end else begin
      $display("** sobel_edge_magnitude_rgb: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sem_pkg.sv
rtl/sem_ram.sv
rtl/sem_lane.sv
rtl/sobel_edge_magnitude_rgb.sv
bench/sobel_edge_magnitude_rgb_tb.sv
